/* src/bgc_pkg.sv */
// Shared types, register indexes and timing constants for the button gesture classifier.
`timescale 1ns / 1ps
package bgc_pkg;

  localparam int unsigned CntW  = 15;
  localparam int unsigned FifoD = 4;

  localparam logic [2:0] MODE_SINGLE = 3'd0;
  localparam logic [2:0] MODE_REPEAT = 3'd1;
  localparam logic [2:0] MODE_TALLY  = 3'd2;
  localparam logic [2:0] MODE_UNFILT = 3'd3;
  localparam logic [2:0] MODE_DUAL   = 3'd4;

  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  localparam logic        ACT_CODE = 1'b0;
  localparam logic        ACT_TICK = 1'b1;

  localparam logic [31:0] HOLD_GAP_MS   = 32'd300;
  localparam logic [31:0] TALLY_GAP_MS  = 32'd250;
  localparam logic [31:0] TALLY_HOLD_MS = 32'd1000;
  localparam logic [CntW-1:0] COUNT_MAX = {CntW{1'b1}};

  localparam logic [2:0]  RST_MODE      = MODE_SINGLE;
  localparam logic [7:0]  RST_THRESHOLD = 8'd1;
  localparam logic [15:0] RST_TIMEOUT   = 16'd300;

  typedef struct packed {
    logic        action;
    logic [31:0] timestamp;
  } in_t;

  typedef struct packed {
    logic signed [15:0] payload;
    logic               last;
  } out_t;

endpackage

/* src/button_gesture_classifier.sv */
// Top level: gesture classification state, result queue and configuration registers.
`timescale 1ns / 1ps
// Takes one code or tick transfer per cycle while in_ready_o is high and updates the
// gesture state in the same cycle; each transfer yields zero, one or two results, which
// go into a four-entry result queue drained at one transfer per cycle while out_ready_i
// is high. in_ready_o is high while the queue has room for two results, so items that
// cause at most one result flow at one per cycle, and a stalled output side backs up the
// input after two or three items that cause results. Configuration writes take effect on
// the next cycle and should be made only while the block is idle.
module button_gesture_classifier (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bgc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bgc_pkg::out_t out_data_o
);
  import bgc_pkg::*;

  localparam int unsigned PtrW  = $clog2(FifoD);
  localparam int unsigned FillW = $clog2(FifoD + 1);

  logic [2:0]      mode_q;
  logic [7:0]      thr_q;
  logic [15:0]     tmo_q;

  logic            active_q, active_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     last_q, last_d;
  logic [31:0]     rstart_q, rstart_d;
  logic            hold_q, hold_d;
  logic            accnext_q, accnext_d;

  logic            in_fire;
  logic [31:0]     ts;
  logic [31:0]     idle;
  logic [31:0]     rdiff;
  logic [CntW-1:0] cnt_b;
  logic [1:0]      n_res;
  logic [15:0]     res0, res1;

  out_t            fifo_q [FifoD];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [FillW-1:0] fill_q;
  logic            pop;

  assign in_fire = in_valid_i && in_ready_o;
  assign ts      = in_data_i.timestamp;
  assign idle    = ts - last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RST_MODE;
      thr_q  <= RST_THRESHOLD;
      tmo_q  <= RST_TIMEOUT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:      mode_q <= cfg_data_i[2:0];
        REG_THRESHOLD: thr_q  <= cfg_data_i[7:0];
        REG_TIMEOUT:   tmo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [15:0] add_res(input logic [1:0] n, input logic [15:0] v,
                                          input logic [15:0] r0);
    add_res = (n == 2'd0) ? v : r0;
  endfunction

  always_comb begin
    active_d  = active_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    rstart_d  = rstart_q;
    hold_d    = hold_q;
    accnext_d = accnext_q;
    n_res     = 2'd0;
    res0      = 16'd0;
    res1      = 16'd0;
    cnt_b     = '0;
    rdiff     = '0;
    if (in_data_i.action == ACT_CODE) begin
      case (mode_q)
        MODE_SINGLE, MODE_DUAL: begin
          cnt_b = active_q ? cnt_q : '0;
          if ((mode_q == MODE_DUAL) && !active_q) begin
            n_res = 2'd1;
          end
          cnt_d = (cnt_b != COUNT_MAX) ? cnt_b + 1'b1 : cnt_b;
          if ({1'b0, cnt_d} == {8'd0, thr_q}) begin
            res0  = add_res(n_res, (mode_q == MODE_DUAL) ? 16'd1 : 16'd0, res0);
            res1  = (mode_q == MODE_DUAL) ? 16'd1 : 16'd0;
            n_res = n_res + 2'd1;
          end
          active_d = 1'b1;
          last_d   = ts;
        end
        MODE_REPEAT: begin
          cnt_b = cnt_q;
          rdiff = ts - rstart_q;
          if (!active_q) begin
            n_res    = 2'd1;
            cnt_b    = '0;
            rstart_d = ts;
            rdiff    = '0;
          end
          cnt_d    = cnt_b;
          active_d = 1'b1;
          last_d   = ts;
          if (rdiff >= HOLD_GAP_MS) begin
            cnt_d = (cnt_b != COUNT_MAX) ? cnt_b + 1'b1 : cnt_b;
            if (thr_q <= 8'd1) begin
              res0  = add_res(n_res, {1'b0, cnt_d}, res0);
              res1  = {1'b0, cnt_d};
              n_res = n_res + 2'd1;
            end else if (cnt_d[0]) begin
              res0  = add_res(n_res, {2'b0, cnt_d[CntW-1:1]}, res0);
              res1  = {2'b0, cnt_d[CntW-1:1]};
              n_res = n_res + 2'd1;
            end
          end
        end
        MODE_TALLY: begin
          last_d = ts;
          if (!active_q) begin
            active_d  = 1'b1;
            hold_d    = 1'b0;
            cnt_d     = CntW'(1);
            rstart_d  = ts;
            res0      = 16'hFFFF;
            n_res     = 2'd1;
            accnext_d = 1'b0;
          end else if (accnext_q) begin
            cnt_d     = (cnt_q != COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
            rstart_d  = ts;
            res0      = 16'd0 - {1'b0, cnt_d};
            n_res     = 2'd1;
            accnext_d = 1'b0;
          end
        end
        MODE_UNFILT: begin
          n_res = 2'd1;
        end
        default: ;
      endcase
    end else if (active_q) begin
      case (mode_q)
        MODE_SINGLE: begin
          if (idle > {16'd0, tmo_q}) begin
            active_d = 1'b0;
            cnt_d    = '0;
          end
        end
        MODE_REPEAT, MODE_DUAL: begin
          if (idle > HOLD_GAP_MS) begin
            active_d = 1'b0;
            cnt_d    = '0;
          end
        end
        MODE_TALLY: begin
          rdiff = ts - rstart_q;
          if (idle >= TALLY_GAP_MS) begin
            accnext_d = 1'b1;
          end
          if (idle >= (hold_q ? TALLY_GAP_MS : TALLY_HOLD_MS)) begin
            if (!hold_q) begin
              res0  = {1'b0, cnt_q};
              n_res = 2'd1;
            end
            hold_d   = 1'b0;
            active_d = 1'b0;
          end else if (rdiff >= TALLY_HOLD_MS && idle < TALLY_GAP_MS && !hold_q) begin
            res0   = 16'd0;
            n_res  = 2'd1;
            hold_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      cnt_q     <= '0;
      last_q    <= '0;
      rstart_q  <= '0;
      hold_q    <= 1'b0;
      accnext_q <= 1'b0;
    end else if (in_fire) begin
      active_q  <= active_d;
      cnt_q     <= cnt_d;
      last_q    <= last_d;
      rstart_q  <= rstart_d;
      hold_q    <= hold_d;
      accnext_q <= accnext_d;
    end
  end

  // result queue
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (fill_q != '0);
  assign out_data_o  = fifo_q[rd_q];
  assign in_ready_o  = (fill_q <= FillW'(FifoD - 2));

  always_ff @(posedge clk_i) begin
    if (in_fire && n_res != 2'd0) begin
      fifo_q[wr_q].payload <= res0;
      fifo_q[wr_q].last    <= (n_res == 2'd1);
      if (n_res == 2'd2) begin
        fifo_q[wr_q + 1'b1].payload <= res1;
        fifo_q[wr_q + 1'b1].last    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (in_fire) begin
        wr_q <= wr_q + PtrW'(n_res);
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      fill_q <= fill_q + (in_fire ? FillW'(n_res) : '0) - FillW'(pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(FifoD))
    else $error("result queue overfilled");

  a_fill_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire || n_res == 2'd0) && !pop |=> $stable(fill_q))
    else $error("queue fill changed without a transfer");

  a_active_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> $past(in_fire && in_data_i.action == ACT_TICK))
    else $error("activity ended without a tick");

  a_accnext_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(accnext_q) |-> $past(mode_q == MODE_TALLY))
    else $error("accept flag set outside tally mode");

  a_unfilt_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && mode_q == MODE_UNFILT && !cfg_we_i |=> $stable(active_q))
    else $error("unfiltered mode changed activity");

endmodule
